// ----- sv/hlt_pkg.sv -----
// shared types and codes for the hdlc link timer block
package hlt_pkg;

  localparam logic [2:0] ST_INIT         = 3'd0;
  localparam logic [2:0] ST_DISC_SENT    = 3'd1;
  localparam logic [2:0] ST_ABM          = 3'd2;
  localparam logic [2:0] ST_WAIT_SABM    = 3'd3;
  localparam logic [2:0] ST_DM_SENT      = 3'd4;
  localparam logic [2:0] ST_WAIT_UA      = 3'd5;
  localparam logic [2:0] ST_SABM_SENT    = 3'd6;
  localparam logic [2:0] ST_DISCONNECTED = 3'd7;

  localparam logic [2:0] FK_NONE = 3'd0;
  localparam logic [2:0] FK_RR   = 3'd1;
  localparam logic [2:0] FK_DISC = 3'd2;
  localparam logic [2:0] FK_FRMR = 3'd3;
  localparam logic [2:0] FK_SABM = 3'd4;
  localparam logic [2:0] FK_DM   = 3'd5;

  localparam logic [0:0] ACT_TICK = 1'b0;
  localparam logic [0:0] ACT_LOAD = 1'b1;

  localparam logic [0:0] REG_T1_TICKS   = 1'b0;
  localparam logic [0:0] REG_N2_RETRIES = 1'b1;

  localparam logic [7:0] T1_TICKS_RST   = 8'd6;
  localparam logic [7:0] N2_RETRIES_RST = 8'd10;

  typedef struct packed {
    logic [2:0] kind;
    logic       poll;
    logic       resend;
    logic       down;
  } frame_ev_t;

  typedef struct packed {
    frame_ev_t [2:0] ev;
    logic [1:0]      cnt;
    logic [2:0]      state;
    logic [15:0]     timeouts;
  } hlt_rec_t;

endpackage

// ----- sv/hlt_front.sv -----
// front part: config registers, link state, timers and event classification
module hlt_front #(
  parameter int TIMER_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [0:0]       cfg_index_i,
  input  logic [7:0]       cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [0:0]       action_i,
  input  logic             interface_up_i,
  input  logic [2:0]       recv_seq_i,
  input  logic [2:0]       last_sent_nr_i,
  input  logic [2:0]       send_seq_i,
  input  logic [2:0]       last_recv_nr_i,
  input  logic [2:0]       load_state_i,
  input  logic [7:0]       load_t1_i,
  input  logic [7:0]       load_rr_i,
  output logic             rec_push_o,
  output hlt_pkg::hlt_rec_t rec_o,
  input  logic             rec_full_i
);
  import hlt_pkg::*;

  logic [7:0]            t1_ticks_q, t1_ticks_d;
  logic [7:0]            n2_q, n2_d;
  logic [2:0]            state_q, state_d;
  logic [TIMER_BITS-1:0] t1_q, t1_d;
  logic [TIMER_BITS-1:0] rr_q, rr_d;
  logic [7:0]            retry_q, retry_d;
  logic [15:0]           tmo_q, tmo_d;

  logic [TIMER_BITS+7:0] load_t1_ext, load_rr_ext, reload_ext;
  logic [7:0]            retry_inc;
  logic                  retry_hit;
  logic                  rr_fire, t1_fire;
  frame_ev_t             t1_ev0, t1_ev1;
  logic [1:0]            t1_n;
  logic                  push;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !rec_full_i;
  assign push        = in_valid_i && !rec_full_i;
  assign rec_push_o  = push;

  assign load_t1_ext = {{TIMER_BITS{1'b0}}, load_t1_i};
  assign load_rr_ext = {{TIMER_BITS{1'b0}}, load_rr_i};
  assign reload_ext  = {{TIMER_BITS{1'b0}}, t1_ticks_q};

  assign retry_inc = retry_q + 8'd1;
  assign retry_hit = (retry_inc == n2_q);
  assign rr_fire   = (rr_q == TIMER_BITS'(1)) && (last_sent_nr_i != recv_seq_i);
  assign t1_fire   = (t1_q == TIMER_BITS'(1));

  always_comb begin
    t1_ev0  = '0;
    t1_ev1  = '0;
    t1_n    = 2'd0;
    retry_d = retry_q;
    state_d = state_q;
    tmo_d   = tmo_q;
    if (t1_fire) begin
      case (state_q)
        ST_INIT, ST_DISC_SENT: begin
          t1_ev0 = '{kind: FK_DISC, poll: 1'b1, resend: 1'b0, down: 1'b0};
          t1_n   = 2'd1;
        end
        ST_ABM: begin
          if (last_recv_nr_i != send_seq_i) begin
            tmo_d  = tmo_q + 16'd1;
            t1_ev0 = '{kind: FK_NONE, poll: 1'b0, resend: 1'b1, down: 1'b0};
            t1_n   = 2'd1;
          end
        end
        ST_WAIT_SABM: begin
          t1_ev0  = '{kind: FK_FRMR, poll: 1'b0, resend: 1'b0, down: 1'b0};
          t1_n    = 2'd1;
          retry_d = retry_hit ? 8'd0 : retry_inc;
          if (retry_hit) begin
            t1_ev1  = '{kind: FK_SABM, poll: 1'b0, resend: 1'b0, down: 1'b0};
            t1_n    = 2'd2;
            state_d = ST_WAIT_UA;
          end
        end
        ST_DM_SENT: begin
          t1_n    = 2'd1;
          retry_d = retry_hit ? 8'd0 : retry_inc;
          if (retry_hit) begin
            t1_ev0  = '{kind: FK_SABM, poll: 1'b0, resend: 1'b0, down: 1'b1};
            state_d = ST_SABM_SENT;
          end else begin
            t1_ev0 = '{kind: FK_DM, poll: 1'b0, resend: 1'b0, down: 1'b0};
          end
        end
        ST_WAIT_UA: begin
          t1_n    = 2'd1;
          retry_d = retry_hit ? 8'd0 : retry_inc;
          if (retry_hit) begin
            t1_ev0  = '{kind: FK_DM, poll: 1'b0, resend: 1'b0, down: 1'b0};
            state_d = ST_DM_SENT;
          end else begin
            t1_ev0 = '{kind: FK_SABM, poll: 1'b0, resend: 1'b0, down: 1'b0};
          end
        end
        ST_SABM_SENT: begin
          t1_ev0 = '{kind: FK_SABM, poll: 1'b1, resend: 1'b0, down: 1'b0};
          t1_n   = 2'd1;
        end
        default: begin
          if (interface_up_i) begin
            state_d = ST_INIT;
          end
        end
      endcase
    end

    t1_d = t1_q;
    rr_d = rr_q;
    if (rr_q != '0) begin
      rr_d = rr_q - TIMER_BITS'(1);
    end
    if (t1_q != '0) begin
      t1_d = t1_fire ? reload_ext[TIMER_BITS-1:0] : t1_q - TIMER_BITS'(1);
    end

    rec_o = '0;
    if (rr_fire) begin
      rec_o.ev[0] = '{kind: FK_RR, poll: 1'b0, resend: 1'b0, down: 1'b0};
      rec_o.ev[1] = t1_ev0;
      rec_o.ev[2] = t1_ev1;
      rec_o.cnt   = t1_n + 2'd1;
    end else begin
      rec_o.ev[0] = t1_ev0;
      rec_o.ev[1] = t1_ev1;
      rec_o.cnt   = (t1_n == 2'd0) ? 2'd1 : t1_n;
    end

    if (action_i == ACT_LOAD) begin
      rec_o   = '0;
      rec_o.cnt = 2'd1;
      state_d = load_state_i;
      t1_d    = load_t1_ext[TIMER_BITS-1:0];
      rr_d    = load_rr_ext[TIMER_BITS-1:0];
      retry_d = retry_q;
      tmo_d   = tmo_q;
    end
    rec_o.state    = state_d;
    rec_o.timeouts = tmo_d;
  end

  always_comb begin
    t1_ticks_d = t1_ticks_q;
    n2_d       = n2_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_T1_TICKS:   t1_ticks_d = cfg_data_i;
        REG_N2_RETRIES: n2_d       = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_ticks_q <= T1_TICKS_RST;
      n2_q       <= N2_RETRIES_RST;
      state_q    <= ST_DISCONNECTED;
      t1_q       <= '0;
      rr_q       <= '0;
      retry_q    <= 8'd0;
      tmo_q      <= 16'd0;
    end else begin
      t1_ticks_q <= t1_ticks_d;
      n2_q       <= n2_d;
      if (push) begin
        state_q <= state_d;
        t1_q    <= t1_d;
        rr_q    <= rr_d;
        retry_q <= retry_d;
        tmo_q   <= tmo_d;
      end
    end
  end

  timeout_only_in_abm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && action_i == ACT_TICK && state_q != ST_ABM) |=> $stable(tmo_q))
    else $error("timeout count moved outside abm");

endmodule

// ----- sv/hlt_fifo.sv -----
// two-entry queue of classified items between front and back
module hlt_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hlt_pkg::hlt_rec_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output hlt_pkg::hlt_rec_t rdata_o
);
  import hlt_pkg::*;

  hlt_rec_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_d;
    end
  end

  count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != 2'd3) && !(push_i && full_o) && !(pop_i && empty_o))
    else $error("queue overflow or underflow");

endmodule

// ----- sv/hlt_back.sv -----
// back part: walks the events of the head item, one result per cycle while the receiver is ready
module hlt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  hlt_pkg::hlt_rec_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        frame_kind_o,
  output logic              poll_on_o,
  output logic              resend_iframes_o,
  output logic              link_down_o,
  output logic [2:0]        state_now_o,
  output logic [15:0]       timeout_total_o,
  output logic              last_o
);
  import hlt_pkg::*;

  logic [1:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  frame_ev_t   ev_q, ev_sel;
  logic [2:0]  state_q;
  logic [15:0] tmo_q;
  logic        last_q;
  logic        load_out, last_ev;

  assign load_out = !empty_i && (!out_valid_q || out_ready_i);
  assign last_ev  = (idx_q == head_i.cnt - 2'd1);
  assign pop_o    = load_out && last_ev;

  always_comb begin
    case (idx_q)
      2'd0:    ev_sel = head_i.ev[0];
      2'd1:    ev_sel = head_i.ev[1];
      default: ev_sel = head_i.ev[2];
    endcase
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load_out) begin
      idx_d       = last_ev ? 2'd0 : idx_q + 2'd1;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      ev_q    <= ev_sel;
      state_q <= head_i.state;
      tmo_q   <= head_i.timeouts;
      last_q  <= last_ev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_kind_o     = ev_q.kind;
  assign poll_on_o        = ev_q.poll;
  assign resend_iframes_o = ev_q.resend;
  assign link_down_o      = ev_q.down;
  assign state_now_o      = state_q;
  assign timeout_total_o  = tmo_q;
  assign last_o           = last_q;

  idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (idx_q < head_i.cnt) && (head_i.cnt != 2'd0))
    else $error("event index beyond item");

  more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && !last_q) |=> out_valid_q)
    else $error("item results broken off");

  idx_zero_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |-> (idx_q == 2'd0))
    else $error("event index left over");

endmodule

// ----- sv/hdlc_link_timer_fsm_top.sv -----
// top level of the hdlc link timer engine
//
// timer engine for one hdlc link. each item on the input channel is either a
// tick, which counts down the ack-delay and t1 timers and acts on expiry, or
// a load that sets link state and both timers. every item gives one to three
// results on the output channel, the final one flagged by last_o. results of
// one item follow in consecutive cycles while the receiver keeps ready high.
// an item is classified in the cycle it is accepted and queued in a
// two-entry queue; the result serializer then moves its results from the
// queue head into the output register, one result per cycle while the
// receiver keeps ready high. when the receiver stalls the output register
// holds its result and the queue fills; in_ready_o drops only when the
// queue holds two items. the configuration channel is always ready; the
// user must write registers t1_ticks (index 0) and n2_retries (index 1)
// only while the block is idle, which the block does not enforce.
// reset gives t1_ticks 6, n2_retries 10, link disconnected, timers stopped,
// retry and timeout counts zero, queue empty and no result pending.
module hdlc_link_timer_fsm_top #(
  parameter int TIMER_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [0:0]  action_i,
  input  logic        interface_up_i,
  input  logic [2:0]  recv_seq_i,
  input  logic [2:0]  last_sent_nr_i,
  input  logic [2:0]  send_seq_i,
  input  logic [2:0]  last_recv_nr_i,
  input  logic [2:0]  load_state_i,
  input  logic [7:0]  load_t1_i,
  input  logic [7:0]  load_rr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  frame_kind_o,
  output logic        poll_on_o,
  output logic        resend_iframes_o,
  output logic        link_down_o,
  output logic [2:0]  state_now_o,
  output logic [15:0] timeout_total_o,
  output logic        last_o
);
  import hlt_pkg::*;

  hlt_rec_t rec_in, rec_head;
  logic     push, full, pop, empty;

  hlt_front #(
    .TIMER_BITS(TIMER_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .interface_up_i(interface_up_i),
    .recv_seq_i    (recv_seq_i),
    .last_sent_nr_i(last_sent_nr_i),
    .send_seq_i    (send_seq_i),
    .last_recv_nr_i(last_recv_nr_i),
    .load_state_i  (load_state_i),
    .load_t1_i     (load_t1_i),
    .load_rr_i     (load_rr_i),
    .rec_push_o    (push),
    .rec_o         (rec_in),
    .rec_full_i    (full)
  );

  hlt_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(rec_in),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .rdata_o(rec_head)
  );

  hlt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .head_i          (rec_head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_kind_o    (frame_kind_o),
    .poll_on_o       (poll_on_o),
    .resend_iframes_o(resend_iframes_o),
    .link_down_o     (link_down_o),
    .state_now_o     (state_now_o),
    .timeout_total_o (timeout_total_o),
    .last_o          (last_o)
  );

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the hdlc link timer engine with a frame scoreboard
module testbench;
  import hlt_pkg::*;

  localparam int TIMER_BITS = 8;
  localparam int MAX_SHOWN  = 10;

  typedef struct packed {
    logic [0:0] action;
    logic       if_up;
    logic [2:0] v_r;
    logic [2:0] nr_sent;
    logic [2:0] v_s;
    logic [2:0] nr_rcvd;
    logic [2:0] new_state;
    logic [7:0] new_t1;
    logic [7:0] new_ack;
  } link_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        poll;
    logic        resend;
    logic        down;
    logic [2:0]  state;
    logic [15:0] timeouts;
    logic        last;
  } frame_rec_t;

  class link_timer_scoreboard;
    logic [7:0]            t1_reload;
    logic [7:0]            n2_limit;
    logic [2:0]            link_st;
    logic [TIMER_BITS-1:0] t1_left;
    logic [TIMER_BITS-1:0] ack_left;
    logic [7:0]            retries;
    logic [15:0]           timeouts;
    frame_rec_t            due_frames[$];
    int unsigned           errors, ticks, loads, frames, resends, downs;
    int unsigned           kind_hits[6];

    function new();
      t1_reload = T1_TICKS_RST;
      n2_limit  = N2_RETRIES_RST;
      link_st   = ST_DISCONNECTED;
      t1_left   = '0;
      ack_left  = '0;
      retries   = '0;
      timeouts  = '0;
    endfunction

    function void note_config(logic [0:0] idx, logic [7:0] val);
      if (idx == REG_T1_TICKS) begin
        t1_reload = val;
      end else begin
        n2_limit = val;
      end
    endfunction

    function frame_ev_t mk_ev(logic [2:0] kind, logic poll, logic resend, logic down);
      return {kind, poll, resend, down};
    endfunction

    function bit retry_hit();
      retries = retries + 8'd1;
      if (retries == n2_limit) begin
        retries = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_item(link_item_t it);
      frame_ev_t  evs[$];
      frame_rec_t rec;
      if (it.action == ACT_LOAD) begin
        loads++;
        link_st  = it.new_state;
        t1_left  = TIMER_BITS'(it.new_t1);
        ack_left = TIMER_BITS'(it.new_ack);
      end else begin
        ticks++;
        if (ack_left != 0) begin
          ack_left = ack_left - 1'b1;
          if (ack_left == 0 && it.nr_sent != it.v_r) evs.push_back(mk_ev(FK_RR, 0, 0, 0));
        end
        if (t1_left != 0) begin
          t1_left = t1_left - 1'b1;
          if (t1_left == 0) begin
            case (link_st)
              ST_INIT, ST_DISC_SENT: begin
                evs.push_back(mk_ev(FK_DISC, 1, 0, 0));
              end
              ST_ABM: begin
                if (it.nr_rcvd != it.v_s) begin
                  timeouts = timeouts + 16'd1;
                  evs.push_back(mk_ev(FK_NONE, 0, 1, 0));
                end
              end
              ST_WAIT_SABM: begin
                evs.push_back(mk_ev(FK_FRMR, 0, 0, 0));
                if (retry_hit()) begin
                  evs.push_back(mk_ev(FK_SABM, 0, 0, 0));
                  link_st = ST_WAIT_UA;
                end
              end
              ST_DM_SENT: begin
                if (retry_hit()) begin
                  link_st = ST_SABM_SENT;
                  evs.push_back(mk_ev(FK_SABM, 0, 0, 1));
                end else begin
                  evs.push_back(mk_ev(FK_DM, 0, 0, 0));
                end
              end
              ST_WAIT_UA: begin
                if (retry_hit()) begin
                  evs.push_back(mk_ev(FK_DM, 0, 0, 0));
                  link_st = ST_DM_SENT;
                end else begin
                  evs.push_back(mk_ev(FK_SABM, 0, 0, 0));
                end
              end
              ST_SABM_SENT: begin
                evs.push_back(mk_ev(FK_SABM, 1, 0, 0));
              end
              default: begin
                if (it.if_up) link_st = ST_INIT;
              end
            endcase
            t1_left = TIMER_BITS'(t1_reload);
          end
        end
      end
      if (evs.size() == 0) evs.push_back(mk_ev(FK_NONE, 0, 0, 0));
      for (int k = 0; k < evs.size(); k++) begin
        rec = {evs[k], link_st, timeouts, (k == evs.size() - 1)};
        due_frames.push_back(rec);
      end
    endfunction

    function string show(frame_rec_t r);
      return $sformatf("kind %0d poll %0b resend %0b down %0b state %0d timeouts %0d last %0b",
                       r.kind, r.poll, r.resend, r.down, r.state, r.timeouts, r.last);
    endfunction

    function void check_frame(frame_rec_t got);
      frame_rec_t want;
      if (due_frames.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN) $display("result with no item waiting: %s", show(got));
        return;
      end
      want = due_frames.pop_front();
      frames++;
      if (want.kind < 6) kind_hits[want.kind]++;
      resends += want.resend;
      downs   += want.down;
      if (got !== want) begin
        errors++;
        if (errors <= MAX_SHOWN) begin
          $display("result mismatch after %0d results", frames);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction

    function int unsigned waiting();
      return due_frames.size();
    endfunction

    function void close_out();
      if (due_frames.size() != 0) begin
        if (errors < MAX_SHOWN) $display("%0d expected results never arrived", due_frames.size());
        errors += due_frames.size();
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i    = '0;
  logic [7:0]  cfg_data_i     = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [0:0]  action_i       = '0;
  logic        interface_up_i = 1'b0;
  logic [2:0]  recv_seq_i     = '0;
  logic [2:0]  last_sent_nr_i = '0;
  logic [2:0]  send_seq_i     = '0;
  logic [2:0]  last_recv_nr_i = '0;
  logic [2:0]  load_state_i   = '0;
  logic [7:0]  load_t1_i      = '0;
  logic [7:0]  load_rr_i      = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [2:0]  frame_kind_o;
  logic        poll_on_o;
  logic        resend_iframes_o;
  logic        link_down_o;
  logic [2:0]  state_now_o;
  logic [15:0] timeout_total_o;
  logic        last_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  link_timer_scoreboard frame_board = new();

  hdlc_link_timer_fsm_top #(
    .TIMER_BITS(TIMER_BITS)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .interface_up_i  (interface_up_i),
    .recv_seq_i      (recv_seq_i),
    .last_sent_nr_i  (last_sent_nr_i),
    .send_seq_i      (send_seq_i),
    .last_recv_nr_i  (last_recv_nr_i),
    .load_state_i    (load_state_i),
    .load_t1_i       (load_t1_i),
    .load_rr_i       (load_rr_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_kind_o    (frame_kind_o),
    .poll_on_o       (poll_on_o),
    .resend_iframes_o(resend_iframes_o),
    .link_down_o     (link_down_o),
    .state_now_o     (state_now_o),
    .timeout_total_o (timeout_total_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      frame_board.check_frame({frame_kind_o, poll_on_o, resend_iframes_o, link_down_o,
                               state_now_o, timeout_total_o, last_o});
    end
  end

  function automatic link_item_t rand_item();
    link_item_t it;
    it.action    = 1'($urandom_range(1));
    it.if_up     = 1'($urandom_range(1));
    it.v_r       = 3'($urandom_range(7));
    it.nr_sent   = 3'($urandom_range(7));
    it.v_s       = 3'($urandom_range(7));
    it.nr_rcvd   = 3'($urandom_range(7));
    it.new_state = 3'($urandom_range(7));
    it.new_t1    = 8'($urandom_range(255));
    it.new_ack   = 8'($urandom_range(255));
    return it;
  endfunction

  task automatic send_item(input link_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    action_i       <= it.action;
    interface_up_i <= it.if_up;
    recv_seq_i     <= it.v_r;
    last_sent_nr_i <= it.nr_sent;
    send_seq_i     <= it.v_s;
    last_recv_nr_i <= it.nr_rcvd;
    load_state_i   <= it.new_state;
    load_t1_i      <= it.new_t1;
    load_rr_i      <= it.new_ack;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    frame_board.note_item(it);
  endtask

  task automatic send_tick(input logic up, input logic [2:0] vr, input logic [2:0] ltx,
                           input logic [2:0] vs, input logic [2:0] lrx);
    link_item_t it;
    it         = rand_item();
    it.action  = ACT_TICK;
    it.if_up   = up;
    it.v_r     = vr;
    it.nr_sent = ltx;
    it.v_s     = vs;
    it.nr_rcvd = lrx;
    send_item(it);
  endtask

  task automatic rand_tick();
    link_item_t it;
    it        = rand_item();
    it.action = ACT_TICK;
    send_item(it);
  endtask

  task automatic send_load(input logic [2:0] st, input logic [7:0] t1, input logic [7:0] ack);
    link_item_t it;
    it           = rand_item();
    it.action    = ACT_LOAD;
    it.new_state = st;
    it.new_t1    = t1;
    it.new_ack   = ack;
    send_item(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (frame_board.waiting() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_timers(input logic [7:0] t1, input logic [7:0] n2);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_T1_TICKS;
    cfg_data_i  <= t1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    frame_board.note_config(REG_T1_TICKS, t1);
    cfg_index_i <= REG_N2_RETRIES;
    cfg_data_i  <= n2;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    frame_board.note_config(REG_N2_RETRIES, n2);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly a load with short timers followed by a few ticks, some loose noise
  task automatic run_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_item(rand_item());
        sent++;
      end else begin
        send_load(3'($urandom_range(7)), 8'($urandom_range(1, 3)), 8'($urandom_range(0, 3)));
        sent++;
        burst = $urandom_range(1, 6);
        repeat (burst) begin
          rand_tick();
          sent++;
        end
      end
    end
  endtask

  initial begin
    #8000000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 13;
    recv_idle_pct = 62;

    // directed: every link state, both actions, field extremes
    send_tick(1'b1, 3'd7, 3'd0, 3'd7, 3'd0);
    send_load(ST_DISCONNECTED, 8'd1, 8'd0);
    send_tick(1'b0, 3'd0, 3'd0, 3'd0, 3'd0);
    send_load(ST_DISCONNECTED, 8'd1, 8'd0);
    send_tick(1'b1, 3'd3, 3'd3, 3'd5, 3'd5);
    send_load(ST_INIT, 8'd1, 8'd1);
    send_tick(1'b0, 3'd5, 3'd2, 3'd1, 3'd1);
    send_load(ST_DISC_SENT, 8'd1, 8'd1);
    send_tick(1'b1, 3'd4, 3'd4, 3'd0, 3'd0);
    send_load(ST_ABM, 8'd1, 8'd0);
    send_tick(1'b0, 3'd0, 3'd0, 3'd3, 3'd6);
    send_load(ST_ABM, 8'd1, 8'd0);
    send_tick(1'b1, 3'd0, 3'd0, 3'd2, 3'd2);
    send_load(ST_SABM_SENT, 8'd1, 8'd0);
    send_tick(1'b0, 3'd1, 3'd1, 3'd1, 3'd1);
    send_load(ST_WAIT_SABM, 8'd1, 8'd1);
    send_tick(1'b0, 3'd1, 3'd6, 3'd0, 3'd0);
    send_load(ST_DM_SENT, 8'd1, 8'd0);
    send_tick(1'b1, 3'd2, 3'd2, 3'd2, 3'd2);
    send_load(ST_WAIT_UA, 8'd1, 8'd0);
    send_tick(1'b0, 3'd6, 3'd6, 3'd6, 3'd6);
    send_load(ST_ABM, 8'd255, 8'd255);
    send_tick(1'b1, 3'd7, 3'd7, 3'd7, 3'd7);

    // retry limit reached: rr, frmr and sabm from one tick, then dm and link down
    set_timers(8'd1, 8'd4);
    send_load(ST_WAIT_SABM, 8'd1, 8'd1);
    send_tick(1'b1, 3'd2, 3'd3, 3'd0, 3'd0);
    set_timers(8'd1, 8'd1);
    send_tick(1'b0, 3'd0, 3'd0, 3'd0, 3'd0);
    send_tick(1'b1, 3'd0, 3'd0, 3'd0, 3'd0);

    // zero t1 reload leaves t1 stopped
    set_timers(8'd0, 8'd255);
    send_load(ST_ABM, 8'd1, 8'd0);
    send_tick(1'b0, 3'd0, 3'd0, 3'd1, 3'd2);
    send_tick(1'b0, 3'd0, 3'd0, 3'd1, 3'd2);

    set_timers(8'd2, 8'd3);
    run_random(47);

    send_idle_pct = 62;
    recv_idle_pct = 13;
    set_timers(8'd255, 8'd1);
    run_random(47);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_timers(8'($urandom_range(1, 4)), 8'($urandom_range(1, 6)));
    run_random(46);

    drain();
    repeat (16) @(posedge clk_i);
    frame_board.close_out();

    $display("run covered %0d ticks and %0d loads over three handshake mixes, %0d results",
             frame_board.ticks, frame_board.loads, frame_board.frames);
    $display("frames rr %0d disc %0d frmr %0d sabm %0d dm %0d, resends %0d, link down %0d",
             frame_board.kind_hits[FK_RR], frame_board.kind_hits[FK_DISC],
             frame_board.kind_hits[FK_FRMR], frame_board.kind_hits[FK_SABM],
             frame_board.kind_hits[FK_DM], frame_board.resends, frame_board.downs);
    if (frame_board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/hlt_pkg.sv
sv/hlt_front.sv
sv/hlt_fifo.sv
sv/hlt_back.sv
sv/hdlc_link_timer_fsm_top.sv
tb/testbench.sv
